// ----- src/lars_pkg.sv -----
// shared widths and types for the life automaton row step block
package lars_pkg;

    localparam int ROW_W           = 64;
    localparam int CFG_W           = 7;
    localparam int MAX_COLUMNS_DEF = 64;

    // bits one cell shows its left and right neighbors, already masked
    typedef struct packed {
        logic upper;
        logic middle;
        logic fresh;
    } lars_nbr_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_cells;
        logic             frame_done;
    } lars_result_t;

    typedef struct packed {
        logic first_en;
        logic second_en;
    } lars_push_t;

endpackage

// ----- src/life_automaton_row_step.sv -----
// a completing request's results are written into the result queue when it is accepted
// throughput: one row per cycle while s_ready is high; the last row of a frame yields two
// results, and the four-entry result queue's single output port drains one result per cycle
// while m_ready is high; s_ready drops while the queue holds more than two results
// reset (aresetn low, synchronous) clears the held rows, the queue and sets the
// column count to 64
module life_automaton_row_step
    import lars_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_columns_in_use,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ROW_W-1:0] s_row_cells,
    input  logic             s_final_row,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ROW_W-1:0] m_next_cells,
    output logic             m_frame_done
);

    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(64);

    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] cols_next;
    logic             held_reg;
    logic             held_next;
    logic             accept;
    logic             shift_en;
    logic             clear_en;
    logic [ROW_W-1:0] gen_mid;
    logic [ROW_W-1:0] gen_last;
    lars_push_t       push;
    lars_result_t     first_res;
    lars_result_t     second_res;
    lars_result_t     out_res;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;
    assign shift_en  = accept & ~s_final_row;
    assign clear_en  = accept & s_final_row;

    always_comb begin
        cols_next = cols_reg;
        if (cfg_valid && cfg_ready) begin
            cols_next = cfg_columns_in_use;
        end
        held_next = held_reg;
        if (clear_en) begin
            held_next = 1'b0;
        end else if (shift_en) begin
            held_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
            held_reg <= 1'b0;
        end else begin
            cols_reg <= cols_next;
            held_reg <= held_next;
        end
    end

    lars_row #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (shift_en),
        .clear_en  (clear_en),
        .columns   (cols_reg),
        .row_cells (s_row_cells),
        .gen_mid   (gen_mid),
        .gen_last  (gen_last)
    );

    // a lone first row that is also final goes out as the single result
    always_comb begin
        push.first_en         = accept & (held_reg | s_final_row);
        push.second_en        = accept & held_reg & s_final_row;
        first_res.next_cells  = held_reg ? gen_mid : gen_last;
        first_res.frame_done  = ~held_reg;
        second_res.next_cells = gen_last;
        second_res.frame_done = 1'b1;
    end

    lars_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .first_res  (first_res),
        .second_res (second_res),
        .room_two   (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_res    (out_res)
    );

    assign m_next_cells = out_res.next_cells;
    assign m_frame_done = out_res.frame_done;

endmodule

// ----- src/lars_cell.sv -----
// one grid column: holds the two earlier rows' bits and applies the b3/s23 rule
module lars_cell
    import lars_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      shift_en,
    input  logic      clear_en,
    input  logic      col_live,
    input  logic      row_bit,
    input  lars_nbr_t left_nbr,
    input  lars_nbr_t right_nbr,
    output lars_nbr_t own_nbr,
    output logic      gen_mid,
    output logic      gen_last
);

    logic       upper_reg;
    logic       upper_next;
    logic       middle_reg;
    logic       middle_next;
    logic [3:0] count_mid;
    logic [3:0] count_last;

    always_comb begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (clear_en) begin
            upper_next  = 1'b0;
            middle_next = 1'b0;
        end else if (shift_en) begin
            upper_next  = middle_reg;
            middle_next = row_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end else begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
        end
    end

    assign own_nbr.upper  = upper_reg & col_live;
    assign own_nbr.middle = middle_reg & col_live;
    assign own_nbr.fresh  = row_bit & col_live;

    // middle row with the incoming row below it
    assign count_mid = {3'b000, left_nbr.upper} + {3'b000, own_nbr.upper}
                     + {3'b000, right_nbr.upper} + {3'b000, left_nbr.middle}
                     + {3'b000, right_nbr.middle} + {3'b000, left_nbr.fresh}
                     + {3'b000, own_nbr.fresh} + {3'b000, right_nbr.fresh};

    // incoming row as the last one, dead border below
    assign count_last = {3'b000, left_nbr.middle} + {3'b000, own_nbr.middle}
                      + {3'b000, right_nbr.middle} + {3'b000, left_nbr.fresh}
                      + {3'b000, right_nbr.fresh};

    assign gen_mid  = col_live & ((count_mid == 4'd3)
                    | (own_nbr.middle & (count_mid == 4'd2)));
    assign gen_last = col_live & ((count_last == 4'd3)
                    | (own_nbr.fresh & (count_last == 4'd2)));

endmodule

// ----- src/lars_row.sv -----
// row of column cells wired to their neighbors
module lars_row
    import lars_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic             clear_en,
    input  logic [CFG_W-1:0] columns,
    input  logic [ROW_W-1:0] row_cells,
    output logic [ROW_W-1:0] gen_mid,
    output logic [ROW_W-1:0] gen_last
);

    lars_nbr_t nbr [MAX_COLUMNS];

    for (genvar k = 0; k < ROW_W; k++) begin : g_col
        if (k < MAX_COLUMNS) begin : g_cell
            lars_nbr_t left_w;
            lars_nbr_t right_w;
            logic      live_w;

            if (k == 0) begin : g_left_edge
                assign left_w = '0;
            end else begin : g_left
                assign left_w = nbr[k-1];
            end
            if (k == MAX_COLUMNS - 1) begin : g_right_edge
                assign right_w = '0;
            end else begin : g_right
                assign right_w = nbr[k+1];
            end

            assign live_w = (columns > CFG_W'(k));

            lars_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .clear_en  (clear_en),
                .col_live  (live_w),
                .row_bit   (row_cells[k]),
                .left_nbr  (left_w),
                .right_nbr (right_w),
                .own_nbr   (nbr[k]),
                .gen_mid   (gen_mid[k]),
                .gen_last  (gen_last[k])
            );
        end else begin : g_dead
            // columns beyond the build size are always dead
            assign gen_mid[k]  = 1'b0;
            assign gen_last[k] = 1'b0;
        end
    end

endmodule

// ----- src/lars_queue.sv -----
// result queue: up to two results in a cycle, one out on out_ready
module lars_queue
    import lars_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  lars_push_t   push,
    input  lars_result_t first_res,
    input  lars_result_t second_res,
    output logic         room_two,
    output logic         out_valid,
    input  logic         out_ready,
    output lars_result_t out_res
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lars_result_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] wr_plus1;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pop;

    assign pop      = out_valid & out_ready;
    assign wr_plus1 = wr_reg + PTR_W'(1);

    always_comb begin
        wr_next  = wr_reg + PTR_W'(push.first_en) + PTR_W'(push.second_en);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push.first_en) + CNT_W'(push.second_en)
                 - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first_en) begin
            entries_reg[wr_reg] <= first_res;
        end
        if (push.second_en) begin
            entries_reg[wr_plus1] <= second_res;
        end
    end

    assign room_two  = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_res   = entries_reg[rd_reg];

endmodule

// ----- src/lars_checker.sv -----
// port-level checks for the life automaton row step block, with its bind
module lars_checker
    import lars_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CFG_W-1:0] cfg_columns_in_use,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_final_row,
    input logic             m_valid,
    input logic             m_ready,
    input logic [ROW_W-1:0] m_next_cells,
    input logic             m_frame_done
);

    logic zero_cols_reg;

    // tracks a column count of zero, which kills every column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_cols_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            zero_cols_reg <= (cfg_columns_in_use == '0);
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    a_final_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_row) |=> m_valid)
        else $error("final row request left no result");

    a_zero_cols_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && zero_cols_reg) |-> (m_next_cells == '0))
        else $error("live cell with zero columns in use");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_next_cells) && $stable(m_frame_done)))
        else $error("stalled result changed");

endmodule

bind life_automaton_row_step lars_checker u_lars_checker (.*);

// ----- tb/sv/life_automaton_row_step_test.sv -----
// testbench for the life automaton row step block: scoreboard, stimulus and checks
`timescale 1ns / 100ps

module life_automaton_row_step_test;
    import lars_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_CYCLES = 6;

    // next-generation predictor and store of expected rows
    class life_scoreboard;
        bit [CFG_W-1:0] columns;
        bit [ROW_W-1:0] upper_row;
        bit [ROW_W-1:0] middle_row;
        int             rows_held;
        lars_result_t   expected_rows[$];
        int             errors;
        int             rows_taken;
        int             results_checked;
        int             frames_taken;

        function new();
            columns    = 7'd64;
            upper_row  = '0;
            middle_row = '0;
            rows_held  = 0;
            errors     = 0;
            rows_taken = 0;
            results_checked = 0;
            frames_taken    = 0;
        endfunction

        function bit [ROW_W-1:0] column_mask();
            int n;
            n = (columns > 64) ? 64 : int'(columns);
            if (n >= 64) return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        function bit [ROW_W-1:0] next_row(bit [ROW_W-1:0] above, bit [ROW_W-1:0] here,
                                          bit [ROW_W-1:0] below);
            bit [ROW_W-1:0] m;
            bit [ROW_W-1:0] gen;
            int k;
            int j;
            int live;
            m = column_mask();
            above &= m;
            here  &= m;
            below &= m;
            gen = '0;
            for (k = 0; k < ROW_W; k++) begin
                live = 0;
                for (j = k - 1; j <= k + 1; j++) begin
                    if (j >= 0 && j < ROW_W) begin
                        live += above[j] + below[j];
                        if (j != k) live += here[j];
                    end
                end
                if (here[k]) gen[k] = (live == 2 || live == 3);
                else gen[k] = (live == 3);
            end
            return gen & m;
        endfunction

        function void push_expected(bit [ROW_W-1:0] cells, bit done);
            lars_result_t r;
            r.next_cells = cells;
            r.frame_done = done;
            expected_rows.push_back(r);
        endfunction

        function void note_row(bit [ROW_W-1:0] cells, bit fin);
            rows_taken++;
            if (rows_held == 0) begin
                if (!fin) begin
                    upper_row  = '0;
                    middle_row = cells;
                    rows_held  = 1;
                    return;
                end
                push_expected(next_row('0, cells, '0), 1'b1);
            end else begin
                push_expected(next_row(upper_row, middle_row, cells), 1'b0);
                if (!fin) begin
                    upper_row  = middle_row;
                    middle_row = cells;
                    rows_held  = 2;
                    return;
                end
                push_expected(next_row(middle_row, cells, '0), 1'b1);
            end
            frames_taken++;
            upper_row  = '0;
            middle_row = '0;
            rows_held  = 0;
        endfunction

        function void check_result(bit [ROW_W-1:0] cells, bit done);
            lars_result_t e;
            results_checked++;
            if (expected_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected result next_cells=%h frame_done=%b",
                         $time, cells, done);
                return;
            end
            e = expected_rows.pop_front();
            if (e.next_cells !== cells) begin
                errors++;
                $display("%0t: next_cells mismatch expected=%h actual=%h",
                         $time, e.next_cells, cells);
            end
            if (e.frame_done !== done) begin
                errors++;
                $display("%0t: frame_done mismatch expected=%b actual=%b",
                         $time, e.frame_done, done);
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_columns_in_use = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [ROW_W-1:0] s_row_cells = '0;
    logic             s_final_row = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [ROW_W-1:0] m_next_cells;
    logic             m_frame_done;

    life_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int rows_left      = 0;
    int config_writes  = 0;

    life_automaton_row_step dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_columns_in_use(cfg_columns_in_use),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_row_cells       (s_row_cells),
        .s_final_row       (s_final_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_next_cells      (m_next_cells),
        .m_frame_done      (m_frame_done)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_rows.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check each accepted result, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_next_cells, m_frame_done);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_row(input logic [ROW_W-1:0] cells, input logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_row_cells <= cells;
        s_final_row <= fin;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_row(cells, fin);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_quiet();
        while (sb.expected_rows.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_columns(input logic [CFG_W-1:0] value);
        wait_quiet();
        cfg_valid          <= 1'b1;
        cfg_columns_in_use <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        sb.columns = value;
        config_writes++;
    endtask

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return a & b & {$urandom, $urandom};
            4: return a | b;
            5: return (64'h7 << $urandom_range(61)) | (a & b & {$urandom, $urandom});
            default: return a;
        endcase
    endfunction

    // frames run on across phase changes, so some writes land mid-frame
    task automatic send_random_row();
        if (rows_left == 0)
            rows_left = ($urandom_range(99) < 15) ? 1 : $urandom_range(10, 2);
        send_row(random_row(), rows_left == 1);
        rows_left--;
    endtask

    initial begin
        logic [CFG_W-1:0] phase_columns [8];
        int phase;
        int n;

        phase_columns = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd37, 7'd2, 7'd63, 7'd0};
        phase_columns[7] = $urandom_range(127);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single-row frames at the extremes
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        // blinker across a three-row frame
        send_row('0, 1'b0);
        send_row(64'h1c << 20, 1'b0);
        send_row('0, 1'b1);
        // two-row frame, full rows
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // edge columns 0 and 63
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'hc000_0000_0000_0003, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        send_row(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        stop_sending();

        // zero columns: everything dead
        write_columns(7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        stop_sending();
        write_columns(7'd1);
        send_row('1, 1'b0);
        send_row(64'h3, 1'b1);
        stop_sending();
        // beyond the maximum saturates to full width
        write_columns(7'd127);
        send_row('1, 1'b0);
        send_row(64'hf000_0000_0000_000f, 1'b1);
        stop_sending();
        // width changed between the rows of one frame
        write_columns(7'd64);
        send_row('1, 1'b0);
        stop_sending();
        write_columns(7'd5);
        send_row('1, 1'b1);
        stop_sending();

        for (phase = 0; phase < 8; phase++) begin
            write_columns(phase_columns[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (n = 0; n < 156; n++) send_random_row();
            stop_sending();
        end

        recv_stall_pct = 0;
        wait_quiet();
        repeat (QUIET_CYCLES) @(posedge aclk);

        $display("rows sent %0d in %0d complete frames, results checked %0d",
                 sb.rows_taken, sb.frames_taken, sb.results_checked);
        $display("column settings written %0d, stall and idle mixes exercised 4",
                 config_writes);
        if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (sb.expected_rows.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $time, sb.expected_rows.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- life_automaton_row_step.f -----
src/lars_pkg.sv
src/lars_cell.sv
src/lars_row.sv
src/lars_queue.sv
src/life_automaton_row_step.sv
src/lars_checker.sv
tb/sv/life_automaton_row_step_test.sv
